/* rtl/isq_pkg.sv */
// Shared constants, codes and types for the indexed sequence store.
package isq_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] ACT_READ   = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDATA,
    S_INS,
    S_INS_LAST,
    S_DEL,
    S_OUT
  } state_t;

endpackage

/* rtl/indexed_sequence_store.sv */
// Indexed sequence store: ordered list of signed words kept in one RAM.
//
// Input channel in_*: one transfer carries an action (read, insert at
// position, delete at position), a position and a value. Output channel
// out_*: one transfer per input item with the read value, a status
// (done, position out of range, store full) and the entry count after it.
// Items are handled one at a time. A read in range goes through a RAM read
// state. Out-of-range, full, unused action, append and delete of the last
// entry move nothing; an insert inside the sequence moves each later entry up
// one slot and a delete inside it each later entry down one slot, since every
// moved entry is read from and written back to the single entry RAM.
// The next item is accepted once the previous result sits in the output
// register, so one result may wait while the next item is worked on.
// A stalled receiver holds the output register; a finished result then
// waits in the block until the register frees up.
// Reset (rst_n low, synchronous) empties the store and holds in_tready low;
// entry contents are not cleared, since only entries below the count are read.
module indexed_sequence_store (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // action[1:0], position[7:2], value[39:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // read_value[31:0], status[33:32], count[40:34]
);

  isq_pkg::state_t state_r, state_nxt;

  logic [1:0]                   act_r;
  logic [isq_pkg::ADDR_W-1:0]   pos_r;
  logic [isq_pkg::DATA_W-1:0]   val_r;
  logic [isq_pkg::ADDR_W-1:0]   idx_r, idx_nxt;
  logic [isq_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [isq_pkg::DATA_W-1:0]   res_val_r, res_val_nxt;
  logic [1:0]                   res_st_r, res_st_nxt;

  logic                         out_valid_r;
  logic [isq_pkg::DATA_W-1:0]   out_val_r;
  logic [1:0]                   out_st_r;
  logic [isq_pkg::CNT_W-1:0]    out_cnt_r;

  logic                         we;
  logic [isq_pkg::ADDR_W-1:0]   waddr;
  logic [isq_pkg::DATA_W-1:0]   wdata;
  logic [isq_pkg::ADDR_W-1:0]   raddr;
  logic [isq_pkg::DATA_W-1:0]   rdata;

  logic                         in_xfer;
  logic                         out_load;
  logic [isq_pkg::CNT_W-1:0]    pos_ext;
  logic [isq_pkg::CNT_W-1:0]    idx_ext;

  isq_ram #(
    .WIDTH (isq_pkg::DATA_W),
    .DEPTH (isq_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  assign in_tready = rst_n && (state_r == isq_pkg::S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_load  = (state_r == isq_pkg::S_OUT) && (!out_valid_r || out_tready);
  assign pos_ext   = {1'b0, pos_r};
  assign idx_ext   = {1'b0, idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= isq_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_r <= in_tdata[1:0];
      pos_r <= in_tdata[7:2];
      val_r <= in_tdata[39:8];
    end
    idx_r     <= idx_nxt;
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    count_nxt   = count_r;
    res_val_nxt = res_val_r;
    res_st_nxt  = res_st_r;
    we          = 1'b0;
    waddr       = idx_r;
    wdata       = rdata;
    raddr       = pos_r;
    case (state_r)
      isq_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_nxt = isq_pkg::S_EXEC;
        end
      end
      isq_pkg::S_EXEC: begin
        res_val_nxt = '0;
        res_st_nxt  = isq_pkg::ST_DONE;
        state_nxt   = isq_pkg::S_OUT;
        case (act_r)
          isq_pkg::ACT_READ: begin
            if (pos_ext < count_r) begin
              raddr     = pos_r;
              state_nxt = isq_pkg::S_RDATA;
            end else begin
              res_val_nxt = '1;
              res_st_nxt  = isq_pkg::ST_RANGE;
            end
          end
          isq_pkg::ACT_INSERT: begin
            if (pos_ext > count_r) begin
              res_st_nxt = isq_pkg::ST_RANGE;
            end else if (count_r >= isq_pkg::CNT_W'(isq_pkg::DEPTH)) begin
              res_st_nxt = isq_pkg::ST_FULL;
            end else if (pos_ext == count_r) begin
              we        = 1'b1;
              waddr     = pos_r;
              wdata     = val_r;
              count_nxt = count_r + 1'b1;
            end else begin
              // walk down from the end, moving each entry up one slot
              idx_nxt   = count_r[isq_pkg::ADDR_W-1:0];
              raddr     = count_r[isq_pkg::ADDR_W-1:0] - 1'b1;
              state_nxt = isq_pkg::S_INS;
            end
          end
          isq_pkg::ACT_DELETE: begin
            if (pos_ext >= count_r) begin
              res_st_nxt = isq_pkg::ST_RANGE;
            end else if (pos_ext + 1'b1 == count_r) begin
              count_nxt = count_r - 1'b1;
            end else begin
              idx_nxt   = pos_r;
              raddr     = pos_r + 1'b1;
              state_nxt = isq_pkg::S_DEL;
            end
          end
          default: begin
          end
        endcase
      end
      isq_pkg::S_RDATA: begin
        res_val_nxt = rdata;
        state_nxt   = isq_pkg::S_OUT;
      end
      isq_pkg::S_INS: begin
        we      = 1'b1;
        waddr   = idx_r;
        wdata   = rdata;
        idx_nxt = idx_r - 1'b1;
        raddr   = idx_r - 2'd2;
        if (idx_r - 1'b1 == pos_r) begin
          state_nxt = isq_pkg::S_INS_LAST;
        end
      end
      isq_pkg::S_INS_LAST: begin
        we        = 1'b1;
        waddr     = pos_r;
        wdata     = val_r;
        count_nxt = count_r + 1'b1;
        state_nxt = isq_pkg::S_OUT;
      end
      isq_pkg::S_DEL: begin
        we      = 1'b1;
        waddr   = idx_r;
        wdata   = rdata;
        idx_nxt = idx_r + 1'b1;
        raddr   = idx_r + 2'd2;
        if (idx_ext + 2'd2 >= count_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = isq_pkg::S_OUT;
        end
      end
      isq_pkg::S_OUT: begin
        if (out_load) begin
          state_nxt = isq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = isq_pkg::S_IDLE;
      end
    endcase
  end

  // hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_val_r <= res_val_r;
      out_st_r  <= res_st_r;
      out_cnt_r <= count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_cnt_r, out_st_r, out_val_r};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= isq_pkg::CNT_W'(isq_pkg::DEPTH))
    else $error("entry count above depth");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_st_r == isq_pkg::ST_FULL |->
      out_cnt_r == isq_pkg::CNT_W'(isq_pkg::DEPTH) && out_val_r == '0)
    else $error("full status with store not full");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("second item taken while busy");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> {1'b0, waddr} <= count_r)
    else $error("write beyond end of sequence");
`endif

endmodule

/* rtl/isq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module isq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

/* sim/tb.sv */
// Self-checking testbench for the indexed sequence store.
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0]  ACT_NONE   = 2'd3;
  localparam int unsigned IDLE_LIM   = 20000;
  localparam int unsigned RAND_ITEMS = 1750;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [6:0]  count;
  } result_t;

  typedef struct {
    logic [1:0]  act;
    logic [5:0]  pos;
    logic [31:0] val;
    bit          fixed;
    result_t     res;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;

  // shadow copy of the store
  logic [31:0] seq_mem [isq_pkg::DEPTH];
  int unsigned seq_len;
  result_t     pending_q[$];
  int unsigned n_errors;
  int unsigned n_results;
  int unsigned idle_cycles;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_off;
  bit          stim_done;

  indexed_sequence_store dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t apply_action(logic [1:0] act, logic [5:0] pos,
                                           logic [31:0] val);
    result_t r;
    r = '0;
    case (act)
      isq_pkg::ACT_READ: begin
        if (pos < seq_len) r.read_value = seq_mem[pos];
        else begin
          r.read_value = 32'hFFFF_FFFF;
          r.status = isq_pkg::ST_RANGE;
        end
      end
      isq_pkg::ACT_INSERT: begin
        if (pos > seq_len) r.status = isq_pkg::ST_RANGE;
        else if (seq_len >= isq_pkg::DEPTH) r.status = isq_pkg::ST_FULL;
        else begin
          for (int i = seq_len; i > pos; i--) seq_mem[i] = seq_mem[i - 1];
          seq_mem[pos] = val;
          seq_len++;
        end
      end
      isq_pkg::ACT_DELETE: begin
        if (pos < seq_len) begin
          for (int i = pos; i + 1 < seq_len; i++) seq_mem[i] = seq_mem[i + 1];
          seq_len--;
        end else r.status = isq_pkg::ST_RANGE;
      end
      default: ;
    endcase
    r.count = seq_len[6:0];
    return r;
  endfunction

  task automatic send_item(logic [1:0] act, logic [5:0] pos, logic [31:0] val,
                           bit fixed, result_t fixed_res);
    result_t r;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {val, pos, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = apply_action(act, pos, val);
    if (fixed && r != fixed_res) begin
      $error("table row disagrees with predictor: act %0d pos %0d", act, pos);
      n_errors++;
    end
    pending_q.push_back(r);
  endtask

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_off) out_tready <= 1'b0;
    else out_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    result_t got;
    result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got.read_value = out_tdata[31:0];
      got.status     = out_tdata[33:32];
      got.count      = out_tdata[40:34];
      n_results++;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: %h", got);
        n_errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (got.read_value !== exp_r.read_value) begin
          $error("read_value: expected %0d, got %0d", $signed(exp_r.read_value),
                 $signed(got.read_value));
          n_errors++;
        end
        if (got.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, got.status);
          n_errors++;
        end
        if (got.count !== exp_r.count) begin
          $error("count: expected %0d, got %0d", exp_r.count, got.count);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || stim_done)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIM) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    row_t        dir_rows[$];
    row_t        row;
    int          phase;
    int unsigned k;
    int unsigned pick;
    logic [1:0]  act;
    logic [5:0]  pos;
    logic [31:0] val;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    n_errors = 0;
    n_results = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    stim_done = 1'b0;
    seq_len = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: fixed rows carry the expected result typed in
    dir_rows = '{
      '{isq_pkg::ACT_READ,   6'd0,  32'h0,         1,
        '{32'hFFFF_FFFF, isq_pkg::ST_RANGE, 7'd0}},
      '{isq_pkg::ACT_DELETE, 6'd0,  32'h0,         1,
        '{32'h0, isq_pkg::ST_RANGE, 7'd0}},
      '{isq_pkg::ACT_INSERT, 6'd1,  32'h5,         1,
        '{32'h0, isq_pkg::ST_RANGE, 7'd0}},
      '{isq_pkg::ACT_INSERT, 6'd0,  32'h7FFF_FFFF, 1,
        '{32'h0, isq_pkg::ST_DONE, 7'd1}},
      '{isq_pkg::ACT_INSERT, 6'd0,  32'h8000_0000, 1,
        '{32'h0, isq_pkg::ST_DONE, 7'd2}},
      '{isq_pkg::ACT_INSERT, 6'd2,  32'hFFFF_FFFF, 1,
        '{32'h0, isq_pkg::ST_DONE, 7'd3}},
      '{isq_pkg::ACT_INSERT, 6'd1,  32'hA5A5_5A5A, 0,
        '{32'h0, isq_pkg::ST_DONE, 7'd0}},
      '{isq_pkg::ACT_READ,   6'd0,  32'h0,         1,
        '{32'h8000_0000, isq_pkg::ST_DONE, 7'd4}},
      '{isq_pkg::ACT_READ,   6'd1,  32'h0,         0,
        '{32'h0, isq_pkg::ST_DONE, 7'd0}},
      '{isq_pkg::ACT_READ,   6'd3,  32'hFFFF_FFFF, 0,
        '{32'h0, isq_pkg::ST_DONE, 7'd0}},
      '{isq_pkg::ACT_READ,   6'd63, 32'h0,         1,
        '{32'hFFFF_FFFF, isq_pkg::ST_RANGE, 7'd4}},
      '{ACT_NONE,            6'd63, 32'hFFFF_FFFF, 1,
        '{32'h0, isq_pkg::ST_DONE, 7'd4}},
      '{isq_pkg::ACT_DELETE, 6'd1,  32'h0,         0,
        '{32'h0, isq_pkg::ST_DONE, 7'd0}},
      '{isq_pkg::ACT_DELETE, 6'd2,  32'h0,         0,
        '{32'h0, isq_pkg::ST_DONE, 7'd0}},
      '{isq_pkg::ACT_DELETE, 6'd2,  32'h0,         1,
        '{32'h0, isq_pkg::ST_RANGE, 7'd2}},
      '{isq_pkg::ACT_READ,   6'd1,  32'h0,         0,
        '{32'h0, isq_pkg::ST_DONE, 7'd0}}
    };
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_item(row.act, row.pos, row.val, row.fixed, row.res);
    end

    // fill to full, hit the full case, read and delete the last entry, then append it again
    while (seq_len < isq_pkg::DEPTH)
      send_item(isq_pkg::ACT_INSERT, 6'($urandom_range(seq_len)), $urandom, 0, '0);
    send_item(isq_pkg::ACT_INSERT, 6'd0, 32'h1, 1, '{32'h0, isq_pkg::ST_FULL, 7'd64});
    send_item(isq_pkg::ACT_READ, 6'd63, 32'h0, 0, '0);
    send_item(isq_pkg::ACT_DELETE, 6'd63, 32'h0, 0, '0);
    send_item(isq_pkg::ACT_INSERT, 6'd63, 32'h1234_5678, 0, '0);

    // random phases: none, sender idle, receiver stall, both
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 51 : (phase == 3) ? 15 : 0;
      recv_stall_pct = (phase == 2) ? 51 : (phase == 3) ? 15 : 0;
      for (k = 0; k < RAND_ITEMS / 4; k++) begin
        pick = $urandom_range(99);
        // bias inserts/deletes by fill level to sweep the whole range
        if (pick < 40) act = isq_pkg::ACT_READ;
        else if (pick < 97)
          act = ($urandom_range(isq_pkg::DEPTH) >= seq_len) ? isq_pkg::ACT_INSERT
                                                            : isq_pkg::ACT_DELETE;
        else act = ACT_NONE;
        if ($urandom_range(9) == 0) pos = 6'($urandom);
        else if (act == isq_pkg::ACT_INSERT)
          pos = 6'($urandom_range(seq_len > 63 ? 63 : seq_len));
        else pos = (seq_len == 0) ? 6'd0 : 6'($urandom_range(seq_len - 1));
        val = $urandom;
        send_item(act, pos, val, 0, '0);
        if (phase == 0 && k == 100) begin
          // long receiver hold-off while items keep coming
          fork
            begin
              hold_off = 1'b1;
              repeat (300) @(posedge clk);
              hold_off = 1'b0;
            end
          join_none
        end
      end
    end

    in_tvalid <= 1'b0;
    stim_done = 1'b1;
    k = 0;
    while (pending_q.size() != 0 && k < 100000) begin
      @(posedge clk);
      k++;
    end
    repeat (200) @(posedge clk);
    if (pending_q.size() != 0) begin
      $error("%0d results never arrived", pending_q.size());
      n_errors++;
    end
    $display("Covered %0d results over reads, inserts, deletes, full and", n_results);
    $display("out-of-range cases under four idle/stall phases and one long hold-off.");
    if (n_errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
